@@ design/lrbs_pkg.sv @@
`default_nettype none

package lrbs_pkg;

	localparam int RelayCount = 18;
	localparam int SlotW      = 5;
	localparam int CoilW      = 6;
	localparam int SlotV      = 16;
	localparam int SlotH      = 17;

	// request kinds carried in tuser
	localparam logic [1:0] REQ_CMD    = 2'd0;
	localparam logic [1:0] REQ_MASK   = 2'd1;
	localparam logic [1:0] REQ_RESYNC = 2'd2;

	// relay groups of a single command
	localparam logic [1:0] GRP_CAP = 2'd0;
	localparam logic [1:0] GRP_IND = 2'd1;
	localparam logic [1:0] GRP_V   = 2'd2;
	localparam logic [1:0] GRP_H   = 2'd3;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic take;   // accept the input beat and latch new states
		logic emit;   // load current slot into the output register, advance
		logic skip;   // slot unchanged, advance
	} dp_cmd_t;

	typedef struct packed {
		logic has_work;   // the beat on the input yields at least one pulse
		logic cur_set;    // current slot still has to pulse
		logic last_slot;  // current slot is the final pending one
		logic out_free;   // output register can take a beat this cycle
	} dp_stat_t;

	// set-coil connection per relay slot, reset coil is one above
	function automatic logic [CoilW-1:0] set_coil(input logic [SlotW-1:0] slot);
		logic [CoilW-1:0] coil;
		case (slot)
			5'd0:    coil = 6'd0;
			5'd1:    coil = 6'd2;
			5'd2:    coil = 6'd4;
			5'd3:    coil = 6'd6;
			5'd4:    coil = 6'd8;
			5'd5:    coil = 6'd34;
			5'd6:    coil = 6'd10;
			5'd7:    coil = 6'd12;
			5'd8:    coil = 6'd14;
			5'd9:    coil = 6'd16;
			5'd10:   coil = 6'd18;
			5'd11:   coil = 6'd20;
			5'd12:   coil = 6'd22;
			5'd13:   coil = 6'd24;
			5'd14:   coil = 6'd26;
			5'd15:   coil = 6'd28;
			5'd16:   coil = 6'd30;
			5'd17:   coil = 6'd32;
			default: coil = 6'd0;
		endcase
		return coil;
	endfunction

endpackage

`default_nettype wire

@@ design/latching_relay_bank_sequencer_top.sv @@
// a coil beat is loaded into the output register when the scan reaches its pulsing slot
// each input beat is scanned slot by slot up to the last changed relay before the next is taken
// the slot scan counter in the datapath walks the slots; output stalls hold the scan
// an item that pulses nothing leaves the block ready again in the next cycle
// reset (arst_n low, asynchronous): all relay states released, states known, no beat pending
`default_nettype none

module latching_relay_bank_sequencer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// command side
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // relay_group[1:0], relay_index[4:2], action[5], state_mask[23:6]
	input  wire logic [1:0]  s_axis_tuser,  // req_type[1:0]
	// coil pulse side
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // coil_number[5:0], relay_slot[10:6], zero fill[15:11]
	output logic             m_axis_tuser,  // energize[0]
	output logic             m_axis_tlast
);
	import lrbs_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	logic [CoilW-1:0] coil_number;
	logic [SlotW-1:0] relay_slot;

	// controller: idle waits for a beat, scan walks the slots
	lrbs_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	// datapath: relay state, pending pulse vector, output register
	lrbs_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.req_type    (s_axis_tuser),
		.relay_group (s_axis_tdata[1:0]),
		.relay_index (s_axis_tdata[4:2]),
		.action      (s_axis_tdata[5]),
		.state_mask  (s_axis_tdata[23:6]),
		.coil_number (coil_number),
		.relay_slot  (relay_slot),
		.energize    (m_axis_tuser),
		.last        (m_axis_tlast),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready)
	);

	// pack the coil beat, unused top bits held at zero
	assign m_axis_tdata = {5'd0, relay_slot, coil_number};

endmodule

`default_nettype wire

@@ design/lrbs_ctrl.sv @@
`default_nettype none

module lrbs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire lrbs_pkg::dp_stat_t stat,
	output lrbs_pkg::dp_cmd_t      cmd
);
	import lrbs_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid && stat.has_work) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.cur_set && stat.out_free && stat.last_slot) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = 1'b0;
		cmd           = '0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.take      = s_axis_tvalid;
			end
			ST_SCAN: begin
				cmd.emit = stat.cur_set && stat.out_free;
				cmd.skip = !stat.cur_set;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ design/lrbs_datapath.sv @@
`default_nettype none

module lrbs_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire lrbs_pkg::dp_cmd_t           cmd,
	output lrbs_pkg::dp_stat_t               stat,
	input  wire logic [1:0]                  req_type,
	input  wire logic [1:0]                  relay_group,
	input  wire logic [2:0]                  relay_index,
	input  wire logic                        action,
	input  wire logic [lrbs_pkg::RelayCount-1:0] state_mask,
	output logic [lrbs_pkg::CoilW-1:0]       coil_number,
	output logic [lrbs_pkg::SlotW-1:0]       relay_slot,
	output logic                             energize,
	output logic                             last,
	output logic                             out_valid,
	input  wire logic                        out_ready
);
	import lrbs_pkg::*;

	logic [RelayCount-1:0] relay_states_q;
	logic                  states_unknown_q;
	logic [RelayCount-1:0] pend_q;
	logic [SlotW-1:0]      slot_q;
	logic                  out_valid_q;
	logic [CoilW-1:0]      coil_q;
	logic [SlotW-1:0]      slot_out_q;
	logic                  energize_q;
	logic                  last_q;

	logic [RelayCount-1:0] next_states;
	logic [RelayCount-1:0] changed;
	logic [RelayCount-1:0] pend_rest;
	logic                  is_update;
	logic                  cur_on;

	// wanted states after the beat on the input
	always_comb begin
		next_states = relay_states_q;
		case (req_type)
			REQ_CMD: begin
				case (relay_group)
					GRP_CAP: next_states[{2'b00, relay_index}] = action;
					GRP_IND: next_states[{2'b01, relay_index}] = action;
					GRP_V: begin
						next_states[SlotV] = action;
						if (action) begin
							next_states[SlotH] = 1'b0;
						end
					end
					GRP_H: begin
						next_states[SlotH] = action;
						if (action) begin
							next_states[SlotV] = 1'b0;
						end
					end
					default: ;
				endcase
			end
			REQ_MASK: next_states = state_mask;
			default:  ;
		endcase
	end

	assign is_update = (req_type == REQ_CMD) || (req_type == REQ_MASK);
	assign changed   = states_unknown_q ? '1 : (relay_states_q ^ next_states);
	assign pend_rest = pend_q & ~(RelayCount'(1) << slot_q);
	assign cur_on    = relay_states_q[slot_q];

	assign stat.has_work  = is_update && (changed != '0);
	assign stat.cur_set   = pend_q[slot_q];
	assign stat.last_slot = (pend_rest == '0);
	assign stat.out_free  = !out_valid_q || out_ready;

	// relay state and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_states_q   <= '0;
			states_unknown_q <= 1'b0;
			pend_q           <= '0;
			slot_q           <= '0;
		end else begin
			if (cmd.take) begin
				if (req_type == REQ_RESYNC) begin
					states_unknown_q <= 1'b1;
				end else if (is_update) begin
					relay_states_q   <= next_states;
					states_unknown_q <= 1'b0;
					pend_q           <= changed;
					slot_q           <= '0;
				end
			end else if (cmd.emit) begin
				pend_q <= pend_rest;
				slot_q <= slot_q + 1'b1;
			end else if (cmd.skip) begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			coil_q     <= set_coil(slot_q) + {{(CoilW-1){1'b0}}, !cur_on};
			slot_out_q <= slot_q;
			energize_q <= cur_on;
			last_q     <= stat.last_slot;
		end
	end

	assign out_valid   = out_valid_q;
	assign coil_number = coil_q;
	assign relay_slot  = slot_out_q;
	assign energize    = energize_q;
	assign last        = last_q;

`ifndef SYNTHESIS
	a_emit_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> pend_q[slot_q])
		else $error("emit on a slot with nothing pending");
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("emit overwrote an unsent beat");
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q != '0) |-> (slot_q < SlotW'(RelayCount)))
		else $error("scan ran past the last relay with pulses pending");
	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && stat.last_slot) |=> (pend_q == '0))
		else $error("pending pulses left after the final beat");
	a_work_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && stat.has_work) |=> (pend_q != '0 && slot_q == '0))
		else $error("scan not loaded for an item with pulses");
`endif

endmodule

`default_nettype wire

@@ tb/relay_pulse_checker.sv @@
module relay_pulse_checker
	import lrbs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,
	input  wire logic [1:0]  s_axis_tuser,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [15:0] m_axis_tdata,
	input  wire logic        m_axis_tuser,
	input  wire logic        m_axis_tlast,
	output int               mismatches,
	output int               pulses_due,
	output int               pulses_checked,
	output int               beats_taken
);

	typedef struct packed {
		logic [CoilW-1:0] coil_number;
		logic [SlotW-1:0] relay_slot;
		logic             energize;
		logic             last;
	} coil_pulse_t;

	// set-coil wiring per slot, slot 5 sits out of sequence
	localparam logic [CoilW-1:0] SET_COIL [RelayCount] = '{
		6'd0,  6'd2,  6'd4,  6'd6,  6'd8,  6'd34, 6'd10, 6'd12,
		6'd14, 6'd16, 6'd18, 6'd20, 6'd22, 6'd24, 6'd26, 6'd28,
		6'd30, 6'd32
	};

	logic [RelayCount-1:0] wanted_states;
	logic                  states_stale;
	coil_pulse_t           pulse_q [$];
	int                    fail_cnt    = 0;
	int                    checked_cnt = 0;
	int                    beat_cnt    = 0;
	int                    due_cnt     = 0;

	assign mismatches     = fail_cnt;
	assign pulses_due     = due_cnt;
	assign pulses_checked = checked_cnt;
	assign beats_taken    = beat_cnt;

	task automatic predict_pulses(input logic [1:0] req, input logic [23:0] data);
		logic [1:0]            grp;
		logic [2:0]            idx;
		logic                  act;
		logic [RelayCount-1:0] next_states;
		logic [RelayCount-1:0] changed;
		int                    last_slot;
		coil_pulse_t           p;
		grp         = data[1:0];
		idx         = data[4:2];
		act         = data[5];
		next_states = wanted_states;
		if (req == REQ_RESYNC) begin
			states_stale = 1'b1;
		end else if (req == REQ_CMD || req == REQ_MASK) begin
			if (req == REQ_MASK) begin
				next_states = data[23:6];
			end else begin
				case (grp)
					GRP_CAP: next_states[int'(idx)] = act;
					GRP_IND: next_states[int'(idx) + 8] = act;
					GRP_V: begin
						next_states[SlotV] = act;
						if (act) next_states[SlotH] = 1'b0;
					end
					default: begin
						next_states[SlotH] = act;
						if (act) next_states[SlotV] = 1'b0;
					end
				endcase
			end
			changed   = states_stale ? '1 : (wanted_states ^ next_states);
			last_slot = -1;
			for (int i = 0; i < RelayCount; i++)
				if (changed[i]) last_slot = i;
			for (int i = 0; i < RelayCount; i++) begin
				if (changed[i]) begin
					// reset coil is wired one above the set coil
					p.coil_number = SET_COIL[i] + {5'd0, ~next_states[i]};
					p.relay_slot  = SlotW'(i);
					p.energize    = next_states[i];
					p.last        = (i == last_slot);
					pulse_q.push_back(p);
				end
			end
			wanted_states = next_states;
			states_stale  = 1'b0;
		end
	endtask

	task automatic check_pulse(input coil_pulse_t got);
		coil_pulse_t want;
		if (pulse_q.size() == 0) begin
			fail_cnt++;
			$error("unexpected coil beat: coil_number %0d relay_slot %0d",
				got.coil_number, got.relay_slot);
		end else begin
			want = pulse_q.pop_front();
			checked_cnt++;
			if (got.coil_number != want.coil_number) begin
				fail_cnt++;
				$error("coil_number: expected %0d, got %0d", want.coil_number, got.coil_number);
			end
			if (got.relay_slot != want.relay_slot) begin
				fail_cnt++;
				$error("relay_slot: expected %0d, got %0d", want.relay_slot, got.relay_slot);
			end
			if (got.energize != want.energize) begin
				fail_cnt++;
				$error("energize: expected %0d, got %0d", want.energize, got.energize);
			end
			if (got.last != want.last) begin
				fail_cnt++;
				$error("last: expected %0d, got %0d", want.last, got.last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_states = '0;
			states_stale  = 1'b0;
			pulse_q.delete();
			due_cnt = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_pulse({m_axis_tdata[5:0], m_axis_tdata[10:6], m_axis_tuser, m_axis_tlast});
			if (s_axis_tvalid && s_axis_tready) begin
				beat_cnt++;
				predict_pulses(s_axis_tuser, s_axis_tdata);
			end
			due_cnt = pulse_q.size();
		end
	end

endmodule

@@ tb/latching_relay_bank_sequencer_top_tb.sv @@
module latching_relay_bank_sequencer_top_tb;
	import lrbs_pkg::*;

	// request code the block has to ignore
	localparam logic [1:0] REQ_UNUSED  = 2'd3;
	localparam int         ITEMS_PER_PHASE = 100;
	localparam int         HOLD_CYCLES = 250;
	// watchdog limit, with plenty of margin over the worst case
	localparam int         CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // relay_group[1:0], relay_index[4:2], action[5], state_mask[23:6]
	logic [1:0]  s_axis_tuser;   // req_type[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // coil_number[5:0], relay_slot[10:6], zero fill[15:11]
	logic        m_axis_tuser;   // energize[0]
	logic        m_axis_tlast;

	int mismatches;
	int pulses_due;
	int pulses_checked;
	int beats_taken;

	// idle percentages for both ends of the block
	int snd_idle_pct = 17;
	int rcv_idle_pct = 66;
	// each increment asks the receiver for one long hold-off
	int hold_req     = 0;
	int cycle_cnt    = 0;

	always #10 clk = ~clk;

	latching_relay_bank_sequencer_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// predicts the coil pulses of every accepted beat and scores the output
	relay_pulse_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser),
		.m_axis_tlast   (m_axis_tlast),
		.mismatches     (mismatches),
		.pulses_due     (pulses_due),
		.pulses_checked (pulses_checked),
		.beats_taken    (beats_taken)
	);

	// run watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("[latching_relay_bank_sequencer_top] ERROR");
			$finish;
		end
	end

	// receiver: random back-pressure, plus a long hold-off whenever one is requested
	initial begin
		int served;
		int hold_left;
		served        = 0;
		hold_left     = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_req != served) begin
				served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// pack one command word, unused fields are still carried so they can be randomized
	function automatic logic [23:0] relay_word(input logic [1:0] grp, input logic [2:0] idx,
		input logic act, input logic [17:0] mask);
		return {mask, act, idx, grp};
	endfunction

	// offer one beat after a random gap and hold it until the block takes it
	task automatic send_beat(input logic [1:0] req, input logic [23:0] data);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= req;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// stop offering and wait until every predicted pulse has come out
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pulses_due != 0) @(posedge clk);
	endtask

	task automatic directed_items();
		// mask equal to the reset state pulses nothing
		send_beat(REQ_MASK, relay_word(GRP_CAP, 3'd0, 1'b0, 18'h00000));
		// group and index extremes, slot 5 has the odd coil wiring
		send_beat(REQ_CMD, relay_word(GRP_CAP, 3'd0, 1'b1, 18'h3FFFF));
		send_beat(REQ_CMD, relay_word(GRP_CAP, 3'd7, 1'b1, 18'h00000));
		send_beat(REQ_CMD, relay_word(GRP_CAP, 3'd5, 1'b1, 18'h15555));
		send_beat(REQ_CMD, relay_word(GRP_CAP, 3'd5, 1'b0, 18'h2AAAA));
		send_beat(REQ_CMD, relay_word(GRP_IND, 3'd0, 1'b1, 18'h00000));
		send_beat(REQ_CMD, relay_word(GRP_IND, 3'd7, 1'b1, 18'h3FFFF));
		// repeat of the same command changes nothing
		send_beat(REQ_CMD, relay_word(GRP_IND, 3'd7, 1'b1, 18'h00000));
		// V and H exclude each other on set, index is a don't-care here
		send_beat(REQ_CMD, relay_word(GRP_V, 3'd7, 1'b1, 18'h3FFFF));
		send_beat(REQ_CMD, relay_word(GRP_H, 3'd5, 1'b1, 18'h00000));
		send_beat(REQ_CMD, relay_word(GRP_V, 3'd0, 1'b1, 18'h00000));
		send_beat(REQ_CMD, relay_word(GRP_V, 3'd2, 1'b0, 18'h00000));
		// release of H while already released
		send_beat(REQ_CMD, relay_word(GRP_H, 3'd3, 1'b0, 18'h00000));
		send_beat(REQ_CMD, relay_word(GRP_H, 3'd3, 1'b1, 18'h00000));
		send_beat(REQ_CMD, relay_word(GRP_H, 3'd6, 1'b0, 18'h00000));
		// short form, V and H may both be loaded set
		send_beat(REQ_MASK, relay_word(GRP_H, 3'd7, 1'b1, 18'h3FFFF));
		send_beat(REQ_MASK, relay_word(GRP_CAP, 3'd0, 1'b0, 18'h15555));
		send_beat(REQ_MASK, relay_word(GRP_CAP, 3'd0, 1'b0, 18'h00000));
		// resync then a no-op command still pulses every relay
		send_beat(REQ_RESYNC, relay_word(GRP_IND, 3'd4, 1'b1, 18'h3FFFF));
		send_beat(REQ_CMD, relay_word(GRP_CAP, 3'd0, 1'b0, 18'h00000));
		// unused request between resync and command leaves the resync pending
		send_beat(REQ_RESYNC, relay_word(GRP_CAP, 3'd0, 1'b0, 18'h00000));
		send_beat(REQ_UNUSED, relay_word(GRP_H, 3'd7, 1'b1, 18'h3FFFF));
		send_beat(REQ_CMD, relay_word(GRP_IND, 3'd3, 1'b1, 18'h00000));
		send_beat(REQ_UNUSED, relay_word(GRP_CAP, 3'd0, 1'b0, 18'h00000));
		send_beat(REQ_MASK, relay_word(GRP_CAP, 3'd0, 1'b0, 18'h2AAAA));
	endtask

	// mostly commands, some masks and resyncs; ignored requests are extra
	task automatic random_items(input int n);
		int          taken;
		int          pick;
		logic [23:0] word;
		taken = 0;
		while (taken < n) begin
			pick = $urandom_range(99);
			word = 24'($urandom);
			if (pick < 60) begin
				send_beat(REQ_CMD, word);
				taken++;
			end else if (pick < 85) begin
				case ($urandom_range(3))
					0:       word[23:6] = '1;
					1:       word[23:6] = '0;
					default: ;
				endcase
				send_beat(REQ_MASK, word);
				taken++;
			end else if (pick < 93) begin
				send_beat(REQ_RESYNC, word);
				taken++;
			end else begin
				send_beat(REQ_UNUSED, word);
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = REQ_CMD;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// light sender gaps, heavy receiver stalls
		directed_items();
		drain();
		random_items(ITEMS_PER_PHASE);
		drain();

		// heavy sender gaps, light receiver stalls
		snd_idle_pct = 66;
		rcv_idle_pct <= 17;
		random_items(ITEMS_PER_PHASE);
		drain();

		// no idling; start with a long receiver hold-off under full-bank traffic
		snd_idle_pct = 0;
		rcv_idle_pct <= 0;
		hold_req <= hold_req + 1;
		repeat (4) begin
			send_beat(REQ_RESYNC, relay_word(GRP_CAP, 3'd0, 1'b0, 18'h00000));
			send_beat(REQ_MASK, relay_word(GRP_CAP, 3'd0, 1'b0, 18'h3FFFF));
			send_beat(REQ_MASK, relay_word(GRP_CAP, 3'd0, 1'b0, 18'h00000));
		end
		drain();
		random_items(ITEMS_PER_PHASE);
		drain();
		repeat (40) @(posedge clk);

		$display("covered %0d request beats and %0d coil pulses over three idle mixes",
			beats_taken, pulses_checked);
		$display("including a %0d-cycle output hold-off and drained pauses", HOLD_CYCLES);
		if (mismatches == 0 && pulses_due == 0) begin
			$display("[latching_relay_bank_sequencer_top] OK");
		end else begin
			$display("[latching_relay_bank_sequencer_top] ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
design/lrbs_pkg.sv
design/lrbs_ctrl.sv
design/lrbs_datapath.sv
design/latching_relay_bank_sequencer_top.sv
tb/relay_pulse_checker.sv
tb/latching_relay_bank_sequencer_top_tb.sv
